FILE: sv/bped_pkg.sv
// ----------------------------------------------------------------------------
// bped_pkg
// Shared types and constants for the button press event detector.
// ----------------------------------------------------------------------------
package bped_pkg;

  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 32;
  localparam int MS_BITS    = 16;
  localparam int IDX_BITS   = 8;
  localparam int DATA_BITS  = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic [MS_BITS-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [MS_BITS-1:0] DOUBLE_PRESS_RST = 16'd300;
  localparam logic [MS_BITS-1:0] DEBOUNCE_RST     = 16'd20;

  typedef enum logic [2:0] {
    EV_SHORT_PRESS   = 3'd0,
    EV_DOUBLE_PRESS  = 3'd1,
    EV_LONG_PRESS    = 3'd2,
    EV_SHORT_RELEASE = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } event_t;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_ACTIVE_LOW   = 8'd0,
    CFG_LONG_PRESS   = 8'd1,
    CFG_DOUBLE_PRESS = 8'd2,
    CFG_DEBOUNCE     = 8'd3
  } cfg_index_t;

  typedef struct packed {
    event_t                code;
    logic                  pressed;
    logic [COUNT_BITS-1:0] total;
    logic [TIME_BITS-1:0]  press_time;
    logic                  last;
  } result_t;

endpackage

FILE: sv/button_press_event_detector_top.sv
// ----------------------------------------------------------------------------
// button_press_event_detector_top
// Debounces a polled pin and emits press, double, long and release events.
// An accepted tick is registered in an input stage, then processed into the result queue.
// Throughput: one tick per cycle; stall input while fewer than two of four queue slots are free.
// Reset: synchronous rst clears state, restores register defaults, empties queue.
// ----------------------------------------------------------------------------
module button_press_event_detector_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bped_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [bped_pkg::DATA_BITS-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            pin_level,
  input  logic [bped_pkg::TIME_BITS-1:0]  now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_code,
  output logic                            pressed,
  output logic [bped_pkg::COUNT_BITS-1:0] press_total,
  output logic [bped_pkg::TIME_BITS-1:0]  last_press_time,
  output logic                            last_of_run
);

  logic                           pin_invert;
  logic [bped_pkg::MS_BITS-1:0]   long_limit;
  logic [bped_pkg::MS_BITS-1:0]   double_limit;
  logic [bped_pkg::MS_BITS-1:0]   settle_limit;

  logic                           raw_seen, raw_seen_next;
  logic                           stable_level, stable_level_next;
  logic [bped_pkg::TIME_BITS-1:0] hold_off_end, hold_off_end_next;
  logic [bped_pkg::TIME_BITS-1:0] press_start, press_start_next;
  logic                           press_recorded, press_recorded_next;
  logic [bped_pkg::TIME_BITS-1:0] prev_press_time, prev_press_time_next;
  logic                           prev_press_valid, prev_press_valid_next;
  logic                           long_done, long_done_next;
  logic [bped_pkg::COUNT_BITS-1:0] press_counter, press_counter_next;

  logic                           s1_valid;
  logic                           s1_pin;
  logic [bped_pkg::TIME_BITS-1:0] s1_now;

  bped_pkg::result_t              fifo_mem [bped_pkg::FIFO_DEPTH];
  logic [bped_pkg::PTR_BITS-1:0]  wr_ptr;
  logic [bped_pkg::PTR_BITS-1:0]  rd_ptr;
  logic [bped_pkg::CNT_BITS-1:0]  count;

  logic                           proc;
  logic                           in_take;
  logic                           pop;
  logic [1:0]                     ev_n;
  bped_pkg::event_t               ev0, ev1;
  logic                           level;
  logic [bped_pkg::TIME_BITS-1:0] hold_dist;
  logic                           in_hold;
  bped_pkg::result_t              res0, res1;

  assign cfg_ready = 1'b1;
  assign proc      = s1_valid && (count <= bped_pkg::CNT_BITS'(bped_pkg::FIFO_DEPTH - 2));
  assign in_stall  = s1_valid && !proc;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_invert   <= 1'b0;
      long_limit   <= bped_pkg::LONG_PRESS_RST;
      double_limit <= bped_pkg::DOUBLE_PRESS_RST;
      settle_limit <= bped_pkg::DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bped_pkg::CFG_ACTIVE_LOW:   pin_invert <= cfg_data[0];
        bped_pkg::CFG_LONG_PRESS:   if (cfg_data != '0) long_limit <= cfg_data;
        bped_pkg::CFG_DOUBLE_PRESS: if (cfg_data != '0) double_limit <= cfg_data;
        bped_pkg::CFG_DEBOUNCE:     if (cfg_data != '0) settle_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin <= pin_level;
      s1_now <= now_ms;
    end
  end

  always_comb begin
    raw_seen_next         = raw_seen;
    stable_level_next     = stable_level;
    hold_off_end_next     = hold_off_end;
    press_start_next      = press_start;
    press_recorded_next   = press_recorded;
    prev_press_time_next  = prev_press_time;
    prev_press_valid_next = prev_press_valid;
    long_done_next        = long_done;
    press_counter_next    = press_counter;
    ev_n                  = 2'd0;
    ev0                   = bped_pkg::EV_SHORT_PRESS;
    ev1                   = bped_pkg::EV_DOUBLE_PRESS;
    level                 = s1_pin ^ pin_invert;
    hold_dist             = hold_off_end - s1_now;
    in_hold = (hold_dist != '0) &&
              (hold_dist <= bped_pkg::TIME_BITS'(settle_limit));
    if (in_hold) begin
      ev_n = 2'd0;
    end else if (level != raw_seen) begin
      raw_seen_next     = level;
      hold_off_end_next = s1_now + bped_pkg::TIME_BITS'(settle_limit);
    end else if (level != stable_level) begin
      stable_level_next = level;
      if (level) begin
        press_start_next      = s1_now;
        press_recorded_next   = 1'b1;
        long_done_next        = 1'b0;
        press_counter_next    = press_counter + 1'b1;
        prev_press_time_next  = s1_now;
        prev_press_valid_next = 1'b1;
        ev0                   = bped_pkg::EV_SHORT_PRESS;
        if (prev_press_valid &&
            ((s1_now - prev_press_time) < bped_pkg::TIME_BITS'(double_limit))) begin
          ev_n = 2'd2;
        end else begin
          ev_n = 2'd1;
        end
      end else if (press_recorded) begin
        press_recorded_next = 1'b0;
        ev0  = long_done ? bped_pkg::EV_LONG_RELEASE : bped_pkg::EV_SHORT_RELEASE;
        ev_n = 2'd1;
      end
    end else if (stable_level && !long_done &&
                 ((s1_now - press_start) >= bped_pkg::TIME_BITS'(long_limit))) begin
      long_done_next = 1'b1;
      ev0            = bped_pkg::EV_LONG_PRESS;
      ev_n           = 2'd1;
    end
    res0.code       = ev0;
    res0.pressed    = stable_level_next;
    res0.total      = press_counter_next;
    res0.press_time = prev_press_time_next;
    res0.last       = (ev_n == 2'd1);
    res1.code       = ev1;
    res1.pressed    = stable_level_next;
    res1.total      = press_counter_next;
    res1.press_time = prev_press_time_next;
    res1.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen         <= 1'b0;
      stable_level     <= 1'b0;
      hold_off_end     <= '0;
      press_start      <= '0;
      press_recorded   <= 1'b0;
      prev_press_time  <= '0;
      prev_press_valid <= 1'b0;
      long_done        <= 1'b0;
      press_counter    <= '0;
    end else if (proc) begin
      raw_seen         <= raw_seen_next;
      stable_level     <= stable_level_next;
      hold_off_end     <= hold_off_end_next;
      press_start      <= press_start_next;
      press_recorded   <= press_recorded_next;
      prev_press_time  <= prev_press_time_next;
      prev_press_valid <= prev_press_valid_next;
      long_done        <= long_done_next;
      press_counter    <= press_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && ev_n != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (proc && ev_n == 2'd2) begin
      fifo_mem[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (proc) begin
        wr_ptr <= wr_ptr + bped_pkg::PTR_BITS'(ev_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + bped_pkg::CNT_BITS'(proc ? ev_n : 2'd0)
                     - bped_pkg::CNT_BITS'(pop);
    end
  end

  assign event_code      = fifo_mem[rd_ptr].code;
  assign pressed         = fifo_mem[rd_ptr].pressed;
  assign press_total     = fifo_mem[rd_ptr].total;
  assign last_press_time = fifo_mem[rd_ptr].press_time;
  assign last_of_run     = fifo_mem[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bped_pkg::CNT_BITS'(bped_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_pair_is_press: assert property (@(posedge clk) disable iff (rst)
    (proc && ev_n == 2'd2) |-> (ev0 == bped_pkg::EV_SHORT_PRESS && stable_level_next))
    else $error("two events from a tick that is not a press");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && count > bped_pkg::CNT_BITS'(bped_pkg::FIFO_DEPTH - 2)) |=>
      (s1_valid && $stable(s1_now)))
    else $error("pending tick lost while queue full");

  a_release_level: assert property (@(posedge clk) disable iff (rst)
    (proc && ev_n == 2'd1 && (ev0 == bped_pkg::EV_SHORT_RELEASE ||
      ev0 == bped_pkg::EV_LONG_RELEASE)) |=> !stable_level && !press_recorded)
    else $error("release event without released state");

endmodule
